// File: sv/button_press_ui_controller_macros.svh
// Assertion helpers for the bpui checker.
`ifndef BUTTON_PRESS_UI_CONTROLLER_MACROS_SVH
`define BUTTON_PRESS_UI_CONTROLLER_MACROS_SVH

// Next-cycle implication, off while reset is asserted.
`define BPUI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpui check failed");

// Next-cycle implication that also runs through reset.
`define BPUI_ASSERT_NEXT_NR(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bpui check failed");

`endif

// File: sv/bpui_pkg.sv
package bpui_pkg;

  // defaults for top-level parameters
  localparam int TIME_BITS_DEF = 32;

  // fixed sizing of the target and mode rings
  localparam int TARGET_COUNT = 4;
  localparam int MODE_TOTAL   = 3;

  // field widths
  localparam int NOW_W  = 32;
  localparam int VOL_W  = 7;
  localparam int STEP_W = 6;
  localparam int MSEC_W = 16;
  localparam int MODE_W = 2;
  localparam int TGT_W  = 2;

  // register port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef struct packed {
    logic [MSEC_W-1:0] long_press_time;
    logic [MSEC_W-1:0] mode_repeat_time;
    logic [MSEC_W-1:0] volume_repeat_time;
    logic [MSEC_W-1:0] volume_edge_pause;
    logic [STEP_W-1:0] volume_step_size;
    logic [VOL_W-1:0]  volume_ceiling;
  } cfg_t;

  typedef struct packed {
    logic [NOW_W-1:0]  now_ms;
    logic              pressed;
    logic [VOL_W-1:0]  current_volume;
    logic [MODE_W-1:0] current_mode;
    logic              hotspot_on;
    logic              network_on;
  } in_item_t;

  typedef struct packed {
    logic [TGT_W-1:0]  selected_target;
    logic              target_changed;
    logic              volume_write;
    logic [VOL_W-1:0]  new_volume;
    logic              mode_write;
    logic [MODE_W-1:0] new_mode;
    logic              hotspot_write;
    logic              new_hotspot;
    logic              network_write;
    logic              new_network;
  } out_item_t;

endpackage

// File: sv/bpui_in_if.sv
interface bpui_in_if;
  logic                      valid;
  logic                      ready;
  logic [bpui_pkg::NOW_W-1:0]  now_ms;
  logic                      pressed;
  logic [bpui_pkg::VOL_W-1:0]  current_volume;
  logic [bpui_pkg::MODE_W-1:0] current_mode;
  logic                      hotspot_on;
  logic                      network_on;

  modport source (
    output valid, now_ms, pressed, current_volume, current_mode, hotspot_on, network_on,
    input  ready
  );

  modport sink (
    input  valid, now_ms, pressed, current_volume, current_mode, hotspot_on, network_on,
    output ready
  );
endinterface

// File: sv/bpui_out_if.sv
interface bpui_out_if;
  logic                      valid;
  logic                      ready;
  logic [bpui_pkg::TGT_W-1:0]  selected_target;
  logic                      target_changed;
  logic                      volume_write;
  logic [bpui_pkg::VOL_W-1:0]  new_volume;
  logic                      mode_write;
  logic [bpui_pkg::MODE_W-1:0] new_mode;
  logic                      hotspot_write;
  logic                      new_hotspot;
  logic                      network_write;
  logic                      new_network;

  modport source (
    output valid, selected_target, target_changed, volume_write, new_volume,
           mode_write, new_mode, hotspot_write, new_hotspot, network_write, new_network,
    input  ready
  );

  modport sink (
    input  valid, selected_target, target_changed, volume_write, new_volume,
           mode_write, new_mode, hotspot_write, new_hotspot, network_write, new_network,
    output ready
  );
endinterface

// File: sv/button_press_ui_controller.sv
// An accepted input beat goes into the input register, its result into the result
// register on out_ch. Throughput: one tick per cycle while out_ch is not stalled;
// the whole tick is one pass of compare/add logic between the two registers.
// Reset (rst_n low, synchronous): both stage valids drop, press state returns
// to idle with the mode target selected, registers take their default values.
module button_press_ui_controller #(
  parameter int TIME_BITS = bpui_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bpui_in_if.sink                      in_ch,
  bpui_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpui_pkg::CFG_AW-1:0]  paddr,
  input  logic [bpui_pkg::CFG_DW-1:0]  pwdata,
  output logic [bpui_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);

  bpui_pkg::cfg_t      cfg;
  bpui_pkg::in_item_t  in_item, in_item_r;
  bpui_pkg::out_item_t res, out_item_r;
  logic                in_v_r, out_v_r;
  logic                advance;

  // Register block: timing and ramp settings, to be written between ticks (not enforced here).
  bpui_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1 -> stage 2 move: the tick in the input register is processed
  // when the result register is empty or its beat is being taken now.
  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  // Input side takes a new beat whenever stage 1 is free or draining,
  // so a waiting result never stalls the input by itself.
  assign in_ch.ready = !in_v_r || advance;

  always_comb begin
    in_item.now_ms         = in_ch.now_ms;
    in_item.pressed        = in_ch.pressed;
    in_item.current_volume = in_ch.current_volume;
    in_item.current_mode   = in_ch.current_mode;
    in_item.hotspot_on     = in_ch.hotspot_on;
    in_item.network_on     = in_ch.network_on;
  end

  // Press tracker: owns target/press/ramp state, updated once per processed
  // tick, so ticks are handled strictly in arrival order.
  bpui_step #(
    .TIME_BITS (TIME_BITS)
  ) u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.selected_target = out_item_r.selected_target;
  assign out_ch.target_changed  = out_item_r.target_changed;
  assign out_ch.volume_write    = out_item_r.volume_write;
  assign out_ch.new_volume      = out_item_r.new_volume;
  assign out_ch.mode_write      = out_item_r.mode_write;
  assign out_ch.new_mode        = out_item_r.new_mode;
  assign out_ch.hotspot_write   = out_item_r.hotspot_write;
  assign out_ch.new_hotspot     = out_item_r.new_hotspot;
  assign out_ch.network_write   = out_item_r.network_write;
  assign out_ch.new_network     = out_item_r.new_network;

endmodule

// File: sv/bpui_cfg.sv
module bpui_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpui_pkg::CFG_AW-1:0]   paddr,
  input  logic [bpui_pkg::CFG_DW-1:0]   pwdata,
  output logic [bpui_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output bpui_pkg::cfg_t                cfg
);

  typedef enum logic [2:0] {
    REG_LONG_PRESS  = 3'd0,
    REG_MODE_REPEAT = 3'd1,
    REG_VOL_REPEAT  = 3'd2,
    REG_VOL_PAUSE   = 3'd3,
    REG_VOL_STEP    = 3'd4,
    REG_VOL_CEIL    = 3'd5
  } cfg_reg_t;

  bpui_pkg::cfg_t cfg_r;
  cfg_reg_t       idx;
  logic           wr;

  assign pready = 1'b1;
  assign idx    = cfg_reg_t'(paddr[bpui_pkg::CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_time    <= 16'd800;
      cfg_r.mode_repeat_time   <= 16'd1200;
      cfg_r.volume_repeat_time <= 16'd100;
      cfg_r.volume_edge_pause  <= 16'd800;
      cfg_r.volume_step_size   <= 6'd2;
      cfg_r.volume_ceiling     <= 7'd100;
    end else if (wr) begin
      unique case (idx)
        REG_LONG_PRESS:  cfg_r.long_press_time    <= pwdata[bpui_pkg::MSEC_W-1:0];
        REG_MODE_REPEAT: cfg_r.mode_repeat_time   <= pwdata[bpui_pkg::MSEC_W-1:0];
        REG_VOL_REPEAT:  cfg_r.volume_repeat_time <= pwdata[bpui_pkg::MSEC_W-1:0];
        REG_VOL_PAUSE:   cfg_r.volume_edge_pause  <= pwdata[bpui_pkg::MSEC_W-1:0];
        REG_VOL_STEP:    cfg_r.volume_step_size   <= pwdata[bpui_pkg::STEP_W-1:0];
        REG_VOL_CEIL:    cfg_r.volume_ceiling     <= pwdata[bpui_pkg::VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS:  prdata = bpui_pkg::CFG_DW'(cfg_r.long_press_time);
      REG_MODE_REPEAT: prdata = bpui_pkg::CFG_DW'(cfg_r.mode_repeat_time);
      REG_VOL_REPEAT:  prdata = bpui_pkg::CFG_DW'(cfg_r.volume_repeat_time);
      REG_VOL_PAUSE:   prdata = bpui_pkg::CFG_DW'(cfg_r.volume_edge_pause);
      REG_VOL_STEP:    prdata = bpui_pkg::CFG_DW'(cfg_r.volume_step_size);
      REG_VOL_CEIL:    prdata = bpui_pkg::CFG_DW'(cfg_r.volume_ceiling);
      default:         prdata = '0;
    endcase
  end

endmodule

// File: sv/bpui_step.sv
module bpui_step #(
  parameter int TIME_BITS = bpui_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  bpui_pkg::in_item_t  item,
  input  bpui_pkg::cfg_t      cfg,
  output bpui_pkg::out_item_t res
);

  typedef enum logic [3:0] {
    PH_UP    = 4'b0001,
    PH_PAUSE = 4'b0010,
    PH_DOWN  = 4'b0100,
    PH_STOP  = 4'b1000
  } phase_t;

  typedef enum logic [bpui_pkg::TGT_W-1:0] {
    TGT_MODE    = 2'd0,
    TGT_VOLUME  = 2'd1,
    TGT_NETWORK = 2'd2,
    TGT_HOTSPOT = 2'd3
  } target_t;

  localparam logic [bpui_pkg::TGT_W-1:0]  TGT_LAST  = bpui_pkg::TGT_W'(bpui_pkg::TARGET_COUNT - 1);
  localparam logic [bpui_pkg::MODE_W-1:0] MODE_CNT  = bpui_pkg::MODE_W'(bpui_pkg::MODE_TOTAL);
  localparam logic [bpui_pkg::MODE_W-1:0] MODE_LAST = bpui_pkg::MODE_W'(bpui_pkg::MODE_TOTAL - 1);

  target_t                target_r, target_nxt;
  logic                   was_r, was_nxt;
  logic                   long_r, long_nxt;
  logic [TIME_BITS-1:0]   start_r, start_nxt;
  logic [TIME_BITS-1:0]   next_r, next_nxt;
  phase_t                 phase_r, phase_nxt;

  logic [TIME_BITS-1:0]   now, start_e, elapsed, since_next;
  logic [TIME_BITS-1:0]   t_mode, t_rep, t_pause;
  logic                   rising, long_e, long_hit, reach, at_ceil, up_top;
  phase_t                 phase_e, ramp_ph, rp_phase;
  logic [TIME_BITS-1:0]   rp_next;
  logic                   rp_vw;
  logic [bpui_pkg::VOL_W-1:0]  rp_vol, vol_dn, step7;
  logic [bpui_pkg::VOL_W:0]    vol_up;
  logic [bpui_pkg::MODE_W-1:0] mode_idx, mode_new;

  always_comb begin
    now        = TIME_BITS'(item.now_ms);
    rising     = item.pressed && !was_r;
    long_e     = rising ? 1'b0 : long_r;
    phase_e    = rising ? PH_STOP : phase_r;
    start_e    = rising ? now : start_r;
    elapsed    = now - start_e;
    long_hit   = !long_e && (elapsed >= TIME_BITS'(cfg.long_press_time));
    since_next = now - next_r;
    reach      = !since_next[TIME_BITS-1];

    t_mode  = now + TIME_BITS'(cfg.mode_repeat_time);
    t_rep   = now + TIME_BITS'(cfg.volume_repeat_time);
    t_pause = now + TIME_BITS'(cfg.volume_edge_pause);

    // out-of-list mode counts as index 0
    mode_idx = (item.current_mode < MODE_CNT) ? item.current_mode : '0;
    mode_new = (mode_idx == MODE_LAST) ? '0 : mode_idx + 2'd1;

    step7   = bpui_pkg::VOL_W'(cfg.volume_step_size);
    vol_up  = {1'b0, item.current_volume} + {1'b0, step7};
    up_top  = vol_up >= {1'b0, cfg.volume_ceiling};
    vol_dn  = (item.current_volume > step7) ? item.current_volume - step7 : '0;
    at_ceil = item.current_volume >= cfg.volume_ceiling;

    // one ramp step; a fresh long press enters at the up phase
    ramp_ph  = long_hit ? PH_UP : phase_e;
    rp_phase = ramp_ph;
    rp_next  = next_r;
    rp_vw    = 1'b0;
    rp_vol   = '0;
    unique case (ramp_ph)
      PH_UP: begin
        rp_vw = 1'b1;
        if (up_top) begin
          rp_vol   = cfg.volume_ceiling;
          rp_phase = PH_PAUSE;
          rp_next  = t_pause;
        end else begin
          rp_vol  = vol_up[bpui_pkg::VOL_W-1:0];
          rp_next = t_rep;
        end
      end
      PH_PAUSE: begin
        rp_phase = PH_DOWN;
        rp_next  = now;
      end
      PH_DOWN: begin
        rp_vw  = 1'b1;
        rp_vol = vol_dn;
        if (vol_dn == '0) begin
          rp_phase = PH_STOP;
        end else begin
          rp_next = t_rep;
        end
      end
      default: ;
    endcase

    target_nxt = target_r;
    was_nxt    = was_r | rising;
    long_nxt   = long_e;
    start_nxt  = start_e;
    next_nxt   = next_r;
    phase_nxt  = phase_e;
    res        = '0;

    if (item.pressed) begin
      if (long_hit) begin
        long_nxt = 1'b1;
        unique case (target_r)
          TGT_MODE: begin
            res.mode_write = 1'b1;
            res.new_mode   = mode_new;
            next_nxt       = t_mode;
          end
          TGT_VOLUME: begin
            if (at_ceil) begin
              phase_nxt = PH_PAUSE;
              next_nxt  = t_pause;
            end else begin
              phase_nxt        = rp_phase;
              next_nxt         = rp_next;
              res.volume_write = rp_vw;
              res.new_volume   = rp_vol;
            end
          end
          TGT_NETWORK: begin
            res.network_write = 1'b1;
            res.new_network   = !item.network_on;
          end
          default: begin
            res.hotspot_write = 1'b1;
            res.new_hotspot   = !item.hotspot_on;
          end
        endcase
      end else if (long_e && reach) begin
        unique case (target_r)
          TGT_MODE: begin
            res.mode_write = 1'b1;
            res.new_mode   = mode_new;
            next_nxt       = t_mode;
          end
          TGT_VOLUME: begin
            phase_nxt        = rp_phase;
            next_nxt         = rp_next;
            res.volume_write = rp_vw;
            res.new_volume   = rp_vol;
          end
          default: ;
        endcase
      end
    end else if (was_r) begin
      if (!long_r) begin
        target_nxt         = (target_r == TGT_LAST) ? TGT_MODE : target_t'(target_r + 2'd1);
        res.target_changed = 1'b1;
      end
      was_nxt   = 1'b0;
      long_nxt  = 1'b0;
      phase_nxt = PH_STOP;
    end

    res.selected_target = target_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TGT_MODE;
      was_r    <= 1'b0;
      long_r   <= 1'b0;
      start_r  <= '0;
      next_r   <= '0;
      phase_r  <= PH_STOP;
    end else if (fire) begin
      target_r <= target_nxt;
      was_r    <= was_nxt;
      long_r   <= long_nxt;
      start_r  <= start_nxt;
      next_r   <= next_nxt;
      phase_r  <= phase_nxt;
    end
  end

endmodule

// File: sv/bpui_checker.sv
`include "button_press_ui_controller_macros.svh"

module bpui_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         pready,
  input logic [bpui_pkg::CFG_AW-1:0]  paddr,
  input logic [bpui_pkg::CFG_DW-1:0]  pwdata,
  input logic [bpui_pkg::CFG_DW-1:0]  prdata
);

  // reset leaves both stages empty
  `BPUI_ASSERT_NEXT_NR(a_reset_empty, clk, !rst_n, !out_valid && in_ready)

  // result beat holds while stalled
  `BPUI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // an accepted beat is checked to show a valid result on out_ch
  `BPUI_ASSERT_NEXT(a_latency, clk, rst_n, $past(in_valid && in_ready && rst_n), out_valid)

  // long-press register reads back what was written
  `BPUI_ASSERT_NEXT(a_cfg_readback, clk, rst_n, psel && penable && pwrite && pready && paddr == '0, paddr != '0 || prdata[15:0] == $past(pwdata[15:0]))

endmodule

bind button_press_ui_controller bpui_checker u_bpui_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .pready    (pready),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

// File: sim/tb_button_press_ui_controller.sv
module tb_button_press_ui_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Codes
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {TGT_MODE, TGT_VOLUME, TGT_NETWORK, TGT_HOTSPOT} target_t;
  typedef enum logic [1:0] {RAMP_UP, RAMP_PAUSE, RAMP_DOWN, RAMP_STOP} ramp_t;
  typedef enum int {
    REG_LONG_PRESS, REG_MODE_REPEAT, REG_VOL_REPEAT,
    REG_VOL_PAUSE, REG_VOL_STEP, REG_VOL_CEIL
  } reg_idx_t;

  localparam int NUM_REGS       = 6;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_TICKS    = 160;
  localparam int PRESSURE_PHASE = 5;
  localparam int HOLD_CYCLES    = 80;   // long output hold-off, fills the pipe
  localparam int SETTLE_CYCLES  = 4;    // pipeline drain plus margin
  localparam int STALL_LIMIT    = 2000; // cycles with no beat on either side

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, register port
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always #5 clk = ~clk;

  bpui_in_if  in_ch();
  bpui_out_if out_ch();

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [bpui_pkg::CFG_AW-1:0] paddr;
  logic [bpui_pkg::CFG_DW-1:0] pwdata;
  logic [bpui_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  button_press_ui_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the controller: settings and press state
  // ---------------------------------------------------------------------------
  logic [15:0] long_ms     = 16'd800;
  logic [15:0] mode_rep_ms = 16'd1200;
  logic [15:0] vol_rep_ms  = 16'd100;
  logic [15:0] pause_ms    = 16'd800;
  logic [5:0]  vol_step    = 6'd2;
  logic [6:0]  vol_ceil    = 7'd100;

  target_t     tgt_sel   = TGT_MODE;
  bit          btn_held  = 1'b0;
  bit          long_on   = 1'b0;
  logic [31:0] press_t0  = '0;
  logic [31:0] due_ms    = '0;
  ramp_t       ramp_st   = RAMP_STOP;

  // Device settings as the host would see them after applying writes; the
  // tick generator feeds these back so ramps and mode cycles progress.
  logic [6:0]  dev_vol  = 7'd50;
  logic [1:0]  dev_mode = 2'd0;
  bit          dev_hot  = 1'b0;
  bit          dev_net  = 1'b0;

  bpui_pkg::in_item_t  tick_q[$];   // ticks waiting for the driver
  bpui_pkg::out_item_t result_q[$]; // predicted results, oldest first

  logic [31:0] gen_now = '0;
  int          ticks_sent   = 0;
  int          results_seen = 0;
  int          fail_cnt     = 0;
  int          moves_seen   = 0;
  int          vol_writes   = 0;
  int          mode_writes  = 0;
  int          flag_writes  = 0;
  int          settings_cnt = 1;
  bit          calm         = 1'b0; // no idling on either side
  bit          hold_req     = 1'b0; // ask the sink for a long hold-off

  // Deadline test on a wrapping ms clock: reached once now - due is "non-negative".
  function automatic bit due_reached(logic [31:0] now);
    logic [31:0] lag;
    lag = now - due_ms;
    return !lag[31];
  endfunction

  // One step of the volume ramp (up, pause at ceiling, down, stopped).
  function automatic void ramp_step(logic [31:0] now, logic [6:0] vol,
                                    inout bpui_pkg::out_item_t r);
    logic [7:0] sum;
    logic [6:0] dn;
    if (ramp_st == RAMP_STOP || !due_reached(now)) return;
    case (ramp_st)
      RAMP_UP: begin
        sum = {1'b0, vol} + {2'b00, vol_step};
        if (sum >= {1'b0, vol_ceil}) begin
          sum     = {1'b0, vol_ceil};
          ramp_st = RAMP_PAUSE;
          due_ms  = now + pause_ms;
        end else begin
          due_ms = now + vol_rep_ms;
        end
        r.volume_write = 1'b1;
        r.new_volume   = sum[6:0];
      end
      RAMP_PAUSE: begin
        ramp_st = RAMP_DOWN;
        due_ms  = now;
      end
      default: begin
        dn = (vol > {1'b0, vol_step}) ? vol - {1'b0, vol_step} : 7'd0;
        r.volume_write = 1'b1;
        r.new_volume   = dn;
        if (dn == 7'd0) ramp_st = RAMP_STOP;
        else due_ms = now + vol_rep_ms;
      end
    endcase
  endfunction

  // Expected result of one polling tick; advances the shadow press state.
  function automatic bpui_pkg::out_item_t predict_tick(bpui_pkg::in_item_t t);
    bpui_pkg::out_item_t r;
    logic [31:0] now;
    logic [1:0]  midx;
    logic [1:0]  nxt_mode;
    r    = '0;
    now  = t.now_ms;
    // a mode outside the list counts as the first one
    midx = (t.current_mode < bpui_pkg::MODE_TOTAL) ? t.current_mode : 2'd0;
    nxt_mode = (midx == bpui_pkg::MODE_TOTAL - 1) ? 2'd0 : midx + 2'd1;

    if (t.pressed && !btn_held) begin
      btn_held = 1'b1;
      long_on  = 1'b0;
      ramp_st  = RAMP_STOP;
      press_t0 = now;
    end

    if (t.pressed) begin
      if (!long_on && (now - press_t0) >= long_ms) begin
        // press just became long: act on the selected target
        long_on = 1'b1;
        case (tgt_sel)
          TGT_MODE: begin
            r.mode_write = 1'b1;
            r.new_mode   = nxt_mode;
            due_ms       = now + mode_rep_ms;
          end
          TGT_VOLUME: begin
            if (t.current_volume >= vol_ceil) begin
              ramp_st = RAMP_PAUSE;
              due_ms  = now + pause_ms;
            end else begin
              ramp_st = RAMP_UP;
              due_ms  = now;
              ramp_step(now, t.current_volume, r);
            end
          end
          TGT_NETWORK: begin
            r.network_write = 1'b1;
            r.new_network   = ~t.network_on;
          end
          default: begin
            r.hotspot_write = 1'b1;
            r.new_hotspot   = ~t.hotspot_on;
          end
        endcase
      end else if (long_on) begin
        if (tgt_sel == TGT_MODE) begin
          if (due_reached(now)) begin
            r.mode_write = 1'b1;
            r.new_mode   = nxt_mode;
            due_ms       = now + mode_rep_ms;
          end
        end else if (tgt_sel == TGT_VOLUME) begin
          ramp_step(now, t.current_volume, r);
        end
      end
    end else if (btn_held) begin
      // release: a short press moves the target on, any ramp ends
      if (!long_on) begin
        tgt_sel = target_t'(tgt_sel + 2'd1);
        r.target_changed = 1'b1;
      end
      btn_held = 1'b0;
      long_on  = 1'b0;
      ramp_st  = RAMP_STOP;
    end

    r.selected_target = tgt_sel;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: pops the tick queue, idles in random bursts, holds on stall
  // ---------------------------------------------------------------------------
  int src_gap     = 0;
  bit src_idle_on = 1'b1;

  always @(posedge clk) begin
    bpui_pkg::in_item_t nxt;
    if ($urandom_range(0, 63) == 0) src_idle_on <= !src_idle_on;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap     <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (src_gap != 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (src_idle_on && !calm && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        src_gap     <= $urandom_range(0, 9);
      end else if (tick_q.size() != 0) begin
        nxt = tick_q.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.now_ms         <= nxt.now_ms;
        in_ch.pressed        <= nxt.pressed;
        in_ch.current_volume <= nxt.current_volume;
        in_ch.current_mode   <= nxt.current_mode;
        in_ch.hotspot_on     <= nxt.hotspot_on;
        in_ch.network_on     <= nxt.network_on;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts plus one long hold-off on request
  // ---------------------------------------------------------------------------
  int snk_gap     = 0;
  int snk_hold    = 0;
  bit snk_idle_on = 1'b1;

  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) snk_idle_on <= !snk_idle_on;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap      <= 0;
      snk_hold     <= 0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      snk_hold     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (snk_hold != 0) begin
      snk_hold     <= snk_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_gap != 0) begin
      snk_gap      <= snk_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_on && !calm && $urandom_range(0, 7) == 0) begin
      snk_gap      <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted tick, compare every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bpui_pkg::in_item_t  tick;
    bpui_pkg::out_item_t want;
    bpui_pkg::out_item_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        tick = {in_ch.now_ms, in_ch.pressed, in_ch.current_volume,
                in_ch.current_mode, in_ch.hotspot_on, in_ch.network_on};
        want = predict_tick(tick);
        // the host applies what the controller asks for
        if (want.volume_write)  dev_vol  = want.new_volume;
        if (want.mode_write)    dev_mode = want.new_mode;
        if (want.hotspot_write) dev_hot  = want.new_hotspot;
        if (want.network_write) dev_net  = want.new_network;
        result_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.selected_target, out_ch.target_changed, out_ch.volume_write,
               out_ch.new_volume, out_ch.mode_write, out_ch.new_mode,
               out_ch.hotspot_write, out_ch.new_hotspot, out_ch.network_write,
               out_ch.new_network};
        if (result_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with nothing expected, got %h", $time, got);
        end else begin
          want = result_q.pop_front();
          results_seen++;
          check_field("selected_target", 32'(want.selected_target),
                      32'(got.selected_target));
          check_field("target_changed",  32'(want.target_changed),
                      32'(got.target_changed));
          check_field("volume_write",    32'(want.volume_write),  32'(got.volume_write));
          check_field("new_volume",      32'(want.new_volume),    32'(got.new_volume));
          check_field("mode_write",      32'(want.mode_write),    32'(got.mode_write));
          check_field("new_mode",        32'(want.new_mode),      32'(got.new_mode));
          check_field("hotspot_write",   32'(want.hotspot_write), 32'(got.hotspot_write));
          check_field("new_hotspot",     32'(want.new_hotspot),   32'(got.new_hotspot));
          check_field("network_write",   32'(want.network_write), 32'(got.network_write));
          check_field("new_network",     32'(want.new_network),   32'(got.new_network));
          moves_seen  += want.target_changed;
          vol_writes  += want.volume_write;
          mode_writes += want.mode_write;
          flag_writes += want.hotspot_write + want.network_write;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without a beat on either channel ends the run
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Register write followed by a read-back through the same port.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask;
    logic [31:0] rd;
    case (idx)
      REG_VOL_STEP: mask = 32'h3F;
      REG_VOL_CEIL: mask = 32'h7F;
      default:      mask = 32'hFFFF;
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bpui_pkg::CFG_AW'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_LONG_PRESS:  long_ms     = value[15:0];
      REG_MODE_REPEAT: mode_rep_ms = value[15:0];
      REG_VOL_REPEAT:  vol_rep_ms  = value[15:0];
      REG_VOL_PAUSE:   pause_ms    = value[15:0];
      REG_VOL_STEP:    vol_step    = value[5:0];
      default:         vol_ceil    = value[6:0];
    endcase
    if (rd !== (value & mask)) begin
      fail_cnt++;
      $display("%0t: register %s read back, expected %0d, got %0d",
               $time, idx.name(), value & mask, rd);
    end
  endtask

  // Queue one tick once the driver has taken the previous one.
  task automatic put_tick(input bpui_pkg::in_item_t t);
    while (tick_q.size() != 0) @(negedge clk);
    tick_q.push_back(t);
    ticks_sent++;
  endtask

  // Tick built from the host's current settings, with occasional noise.
  task automatic send_tick(input bit prs, input logic [31:0] dt);
    bpui_pkg::in_item_t t;
    while (tick_q.size() != 0) @(negedge clk);
    gen_now          = gen_now + dt;
    t.now_ms         = gen_now;
    t.pressed        = prs;
    t.current_volume = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 100)) : dev_vol;
    t.current_mode   = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : dev_mode;
    t.hotspot_on     = ($urandom_range(0, 15) == 0) ? !dev_hot : dev_hot;
    t.network_on     = ($urandom_range(0, 15) == 0) ? !dev_net : dev_net;
    put_tick(t);
  endtask

  // Idle ticks, a press of random length, then a release.
  // Tick spacing scales with the long-press time so both short and long
  // presses occur at every nonzero long-press setting.
  task automatic press_cycle();
    int          lead;
    int          hold;
    logic [31:0] span;
    span = {16'd0, long_ms} / 8 + 1;
    lead = $urandom_range(0, 3);
    case ($urandom_range(0, 3))
      0:       hold = $urandom_range(1, 4);
      1:       hold = $urandom_range(60, 160);
      default: hold = $urandom_range(6, 40);
    endcase
    repeat (lead) send_tick(1'b0, $urandom_range(1, span));
    repeat (hold) send_tick(1'b1, $urandom_range(1, span));
    send_tick(1'b0, $urandom_range(1, span));
  endtask

  // Wait until every tick is in and every result is back, then wait out SETTLE_CYCLES.
  task automatic settle();
    while (tick_q.size() != 0 || in_ch.valid || result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bpui_pkg::in_item_t mk(logic [31:0] now, bit prs, logic [6:0] vol,
                                            logic [1:0] mode, bit hot, bit net);
    bpui_pkg::in_item_t t;
    t = '{now_ms: now, pressed: prs, current_volume: vol, current_mode: mode,
          hotspot_on: hot, network_on: net};
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0]        setv [NUM_REGS];
    bpui_pkg::in_item_t t;
    int                 stop_at;
    bit                 pressured;

    in_ch.valid          = 1'b0;
    in_ch.now_ms         = '0;
    in_ch.pressed        = 1'b0;
    in_ch.current_volume = '0;
    in_ch.current_mode   = '0;
    in_ch.hotspot_on     = 1'b0;
    in_ch.network_on     = 1'b0;
    out_ch.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    pressured            = 1'b0;
    rst_n                = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at reset settings (long press 800, mode repeat 1200,
    // volume repeat 100, pause 800, step 2, ceiling 100).
    put_tick(mk(32'd0, 1'b0, 7'd0, 2'd0, 1'b0, 1'b0));
    // mode target, press across the time wrap, mode outside the list
    put_tick(mk(32'hFFFF_FFFF, 1'b1, 7'd100, 2'd3, 1'b0, 1'b0));
    put_tick(mk(32'h0000_031F, 1'b1, 7'd100, 2'd3, 1'b1, 1'b1));
    put_tick(mk(32'h0000_07CF, 1'b1, 7'd100, 2'd1, 1'b1, 1'b1)); // repeat step
    put_tick(mk(32'h0000_07D0, 1'b0, 7'd100, 2'd2, 1'b0, 1'b0)); // long release
    put_tick(mk(32'd5000, 1'b1, 7'd50, 2'd2, 1'b0, 1'b0));
    put_tick(mk(32'd5001, 1'b0, 7'd50, 2'd2, 1'b0, 1'b0));       // to volume
    // volume at the ceiling: pause, then ramp down
    put_tick(mk(32'd6000, 1'b1, 7'd100, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd6800, 1'b1, 7'd100, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd7600, 1'b1, 7'd100, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd7601, 1'b1, 7'd100, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd7602, 1'b0, 7'd98, 2'd0, 1'b0, 1'b0));
    // volume from zero: ramp up, one step per repeat interval
    put_tick(mk(32'd8000, 1'b1, 7'd0, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd8800, 1'b1, 7'd0, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd8900, 1'b1, 7'd2, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd8950, 1'b1, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd8951, 1'b0, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd9000, 1'b1, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd9001, 1'b0, 7'd4, 2'd0, 1'b0, 1'b0));        // to network
    put_tick(mk(32'd20000, 1'b1, 7'd4, 2'd0, 1'b0, 1'b1));
    put_tick(mk(32'd20800, 1'b1, 7'd4, 2'd0, 1'b0, 1'b1));       // network off
    put_tick(mk(32'd20801, 1'b0, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd21000, 1'b1, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd21001, 1'b0, 7'd4, 2'd0, 1'b0, 1'b0));       // to hotspot
    put_tick(mk(32'd30000, 1'b1, 7'd4, 2'd0, 1'b0, 1'b0));
    put_tick(mk(32'd30800, 1'b1, 7'd4, 2'd0, 1'b0, 1'b0));       // hotspot on
    put_tick(mk(32'd30801, 1'b0, 7'd4, 2'd0, 1'b1, 1'b0));
    put_tick(mk(32'd31000, 1'b1, 7'd4, 2'd0, 1'b1, 1'b0));
    put_tick(mk(32'd31001, 1'b0, 7'd4, 2'd0, 1'b1, 1'b0));       // wraps to mode
    gen_now = 32'd31001;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          // all timers at their floor, smallest step and ceiling
          1: setv = '{32'd1, 32'd1, 32'd1, 32'd0, 32'd1, 32'd1};
          // all timers at their top, biggest step
          2: setv = '{32'd65535, 32'd65535, 32'd65535, 32'd65535, 32'd50, 32'd100};
          // instant long press and a ramp that never moves
          3: setv = '{32'd0, 32'($urandom_range(1, 2000)), 32'($urandom_range(1, 300)),
                      32'($urandom_range(0, 2000)), 32'd0, 32'($urandom_range(1, 100))};
          default: setv = '{32'($urandom_range(1, 4000)), 32'($urandom_range(1, 5000)),
                            32'($urandom_range(1, 600)), 32'($urandom_range(0, 3000)),
                            32'($urandom_range(1, 50)), 32'($urandom_range(1, 100))};
        endcase
        for (int r = 0; r < NUM_REGS; r++) write_reg(reg_idx_t'(r), setv[r]);
        settings_cnt++;
        // fresh time base, often just short of the 32-bit wrap
        gen_now = ($urandom_range(0, 1) == 0) ? $urandom
                                              : 32'hFFFF_FFFF - $urandom_range(0, 300000);
      end
      // final phase runs back to back on both sides
      if (p == NUM_PHASES - 1) calm = 1'b1;

      stop_at = ticks_sent + PHASE_TICKS;
      while (ticks_sent < stop_at) begin
        if (p == PRESSURE_PHASE && !pressured && ticks_sent > stop_at - PHASE_TICKS / 2) begin
          hold_req  = 1'b1;
          pressured = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          // noise: arbitrary fields, sometimes a huge jump in time
          while (tick_q.size() != 0) @(negedge clk);
          gen_now = gen_now + (($urandom_range(0, 3) == 0) ? $urandom
                                                           : $urandom_range(0, 50));
          t.now_ms         = gen_now;
          t.pressed        = 1'($urandom_range(0, 1));
          t.current_volume = 7'($urandom_range(0, 100));
          t.current_mode   = 2'($urandom_range(0, 3));
          t.hotspot_on     = 1'($urandom_range(0, 1));
          t.network_on     = 1'($urandom_range(0, 1));
          put_tick(t);
        end else begin
          press_cycle();
        end
      end
    end

    settle();
    $display("Checked %0d results from %0d ticks over %0d register settings.",
             results_seen, ticks_sent, settings_cnt);
    $display("Target moves %0d, volume writes %0d, mode writes %0d, flag toggles %0d.",
             moves_seen, vol_writes, mode_writes, flag_writes);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
